### hw/rtl/mwis_pkg.sv
`timescale 1ns / 1ps
// Shared constants and word types for the maximum-weight increasing subsequence unit.
package mwis_pkg;

   // Tree geometry: one leaf per key value, node 1 is the root, node 0 unused.
   localparam int KEY_BITS    = 10;
   localparam int NODE_BITS   = KEY_BITS + 1;
   localparam int TREE_DEPTH  = 2 ** NODE_BITS;
   localparam int LVL_BITS    = $clog2(KEY_BITS + 1);

   // Arithmetic widths.
   localparam int WEIGHT_BITS = 24;
   localparam int SUM_BITS    = 48;

   // Each tree entry carries a sequence tag; a stale tag reads as empty.
   localparam int EPOCH_BITS  = 8;
   localparam int ENTRY_BITS  = EPOCH_BITS + SUM_BITS;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX   = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_EMPTY = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic [EPOCH_BITS-1:0]      EPOCH_FIRST = '0;

   typedef struct packed {
      logic [KEY_BITS-1:0]           key;
      logic signed [WEIGHT_BITS-1:0] weight;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] best_ending_here;
      logic signed [SUM_BITS-1:0] best_so_far;
      logic                       final_result;
   } rsp_type;

endpackage

### hw/rtl/mwis_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
module mwis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hw/rtl/max_weight_increasing_subsequence_unit.sv
`timescale 1ns / 1ps
// Top level of the maximum-weight strictly increasing subsequence unit.
//
// Each request word carries a key (used directly as a rank), a signed weight and a last
// flag, and produces exactly one response word: the best chain sum ending at this
// element (48-bit, saturated at +(2^47-1)), the running best over the current sequence,
// and an echo of last. A max segment tree with one leaf per key value lives in a single
// simple dual-port RAM of 2^(KEY_BITS+1) entries. Each item runs through the states in
// order: ST_QUERY streams the KEY_BITS prefix query reads through the RAM read port,
// ST_QLAST drains the last read, ST_SUM forms the saturated sum, ST_PATH streams the
// KEY_BITS+1 leaf-to-root path reads with each write-back in the cycle after its read,
// and ST_PLAST retires the last write and loads the response register. The RAM read
// port sets the rate; items are taken one at a time and req_stall stays high while one
// is in flight. A finished response waits in its own register, so the next item is
// taken while it is still stalled. An item marked last starts a new sequence by bumping
// a tag stored with every entry, so stale entries read as empty without a sweep. After
// reset, and after every 256th sequence when the tag wraps, the unit runs a clearing
// pass over all 2^(KEY_BITS+1) entries during which req_stall is held high.
module max_weight_increasing_subsequence_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mwis_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mwis_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUERY,
      ST_QLAST,
      ST_SUM,
      ST_PATH,
      ST_PLAST,
      ST_WAIT
   } state_type;

   state_type state_ff, state_in;

   logic [mwis_pkg::LVL_BITS-1:0]  cnt_ff, cnt_in;
   logic [mwis_pkg::NODE_BITS-1:0] node_ff, node_in;
   logic [mwis_pkg::KEY_BITS-1:0]  ksh_ff, ksh_in;
   logic [mwis_pkg::NODE_BITS-1:0] clr_ff, clr_in;
   logic [mwis_pkg::EPOCH_BITS-1:0] epoch_ff, epoch_in;

   // Item held for the duration of its work.
   logic [mwis_pkg::KEY_BITS-1:0]           key_ff, key_in;
   logic signed [mwis_pkg::WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic                                    last_ff, last_in;

   logic signed [mwis_pkg::SUM_BITS-1:0] m_ff, m_in;
   logic signed [mwis_pkg::SUM_BITS-1:0] dp_ff, dp_in;
   logic signed [mwis_pkg::SUM_BITS-1:0] best_ff, best_in;

   // Read pipeline tags: what the data returning this cycle belongs to.
   logic                           q_pend_ff, q_pend_in;
   logic                           q_use_ff, q_use_in;
   logic                           p_pend_ff, p_pend_in;
   logic                           p_leaf_ff, p_leaf_in;
   logic [mwis_pkg::NODE_BITS-1:0] p_addr_ff, p_addr_in;
   logic                           raise_ff, raise_in;

   logic              rsp_valid_ff, rsp_valid_in;
   mwis_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // RAM port signals.
   logic                            rd_en;
   logic [mwis_pkg::NODE_BITS-1:0]  rd_addr;
   logic [mwis_pkg::ENTRY_BITS-1:0] rd_data;
   logic                            wr_en;
   logic [mwis_pkg::NODE_BITS-1:0]  wr_addr;
   logic [mwis_pkg::ENTRY_BITS-1:0] wr_data;

   logic signed [mwis_pkg::SUM_BITS-1:0] entry_val;
   logic signed [mwis_pkg::SUM_BITS-1:0] node_new;
   logic signed [mwis_pkg::SUM_BITS-1:0] best_new;
   logic signed [mwis_pkg::SUM_BITS:0]   sum_ext;
   logic                                 slot_free;

   mwis_ram #(
      .WIDTH(mwis_pkg::ENTRY_BITS),
      .DEPTH(mwis_pkg::TREE_DEPTH)
   ) u_tree_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // An entry written under an older sequence tag counts as empty.
   assign entry_val = (rd_data[mwis_pkg::ENTRY_BITS-1:mwis_pkg::SUM_BITS] == epoch_ff)
                      ? rd_data[mwis_pkg::SUM_BITS-1:0] : mwis_pkg::SUM_EMPTY;

   // Raising a leaf to dp lifts every ancestor to max(old, dp).
   assign node_new = (entry_val > dp_ff) ? entry_val : dp_ff;
   assign best_new = (dp_ff > best_ff) ? dp_ff : best_ff;

   assign sum_ext = (mwis_pkg::SUM_BITS+1)'(m_ff) + (mwis_pkg::SUM_BITS+1)'(weight_ff);

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      node_in      = node_ff;
      ksh_in       = ksh_ff;
      clr_in       = clr_ff;
      epoch_in     = epoch_ff;
      key_in       = key_ff;
      weight_in    = weight_ff;
      last_in      = last_ff;
      m_in         = m_ff;
      dp_in        = dp_ff;
      best_in      = best_ff;
      q_pend_in    = 1'b0;
      q_use_in     = q_use_ff;
      p_pend_in    = 1'b0;
      p_leaf_in    = p_leaf_ff;
      p_addr_in    = p_addr_ff;
      raise_in     = raise_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      rd_en   = 1'b0;
      rd_addr = node_ff;
      wr_en   = 1'b0;
      wr_addr = p_addr_ff;
      wr_data = {epoch_ff, node_new};

      // Fold returning query data into the running prefix maximum.
      if (q_pend_ff && q_use_ff && (entry_val > m_ff)) begin
         m_in = entry_val;
      end

      // Write back the path node whose old value returns this cycle.
      if (p_pend_ff) begin
         if (p_leaf_ff) begin
            raise_in = entry_val < dp_ff;
            wr_en    = entry_val < dp_ff;
         end else begin
            wr_en = raise_ff;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {mwis_pkg::EPOCH_FIRST, mwis_pkg::SUM_EMPTY};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               key_in    = req_data.key;
               weight_in = req_data.weight;
               last_in   = req_data.last;
               node_in   = {1'b1, req_data.key};
               ksh_in    = req_data.key;
               cnt_in    = '0;
               m_in      = mwis_pkg::SUM_EMPTY;
               state_in  = ST_QUERY;
            end
         end
         ST_QUERY: begin
            // Left neighbour of the right boundary at this level; use it when the key bit is set.
            rd_en     = 1'b1;
            rd_addr   = node_ff - 1'b1;
            q_pend_in = 1'b1;
            q_use_in  = ksh_ff[0];
            node_in   = node_ff >> 1;
            ksh_in    = ksh_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == mwis_pkg::LVL_BITS'(mwis_pkg::KEY_BITS - 1)) begin
               state_in = ST_QLAST;
            end
         end
         ST_QLAST: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (m_ff > 0) begin
               if (sum_ext > (mwis_pkg::SUM_BITS+1)'(mwis_pkg::SUM_MAX)) begin
                  dp_in = mwis_pkg::SUM_MAX;
               end else begin
                  dp_in = sum_ext[mwis_pkg::SUM_BITS-1:0];
               end
            end else begin
               dp_in = mwis_pkg::SUM_BITS'(weight_ff);
            end
            node_in  = {1'b1, key_ff};
            cnt_in   = '0;
            state_in = ST_PATH;
         end
         ST_PATH: begin
            rd_en     = 1'b1;
            rd_addr   = node_ff;
            p_pend_in = 1'b1;
            p_leaf_in = (cnt_ff == '0);
            p_addr_in = node_ff;
            node_in   = node_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == mwis_pkg::LVL_BITS'(mwis_pkg::KEY_BITS)) begin
               state_in = ST_PLAST;
            end
         end
         ST_PLAST, ST_WAIT: begin
            if (slot_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.best_ending_here = dp_ff;
               rsp_data_in.best_so_far      = best_new;
               rsp_data_in.final_result     = last_ff;
               state_in                     = ST_IDLE;
               if (last_ff) begin
                  // Start a new sequence; sweep the RAM when the tag wraps.
                  best_in  = mwis_pkg::SUM_EMPTY;
                  epoch_in = epoch_ff + 1'b1;
                  if (epoch_ff == '1) begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
               end else begin
                  best_in = best_new;
               end
            end else begin
               state_in = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         epoch_ff     <= mwis_pkg::EPOCH_FIRST;
         best_ff      <= mwis_pkg::SUM_EMPTY;
         cnt_ff       <= '0;
         q_pend_ff    <= 1'b0;
         p_pend_ff    <= 1'b0;
         raise_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         epoch_ff     <= epoch_in;
         best_ff      <= best_in;
         cnt_ff       <= cnt_in;
         q_pend_ff    <= q_pend_in;
         p_pend_ff    <= p_pend_in;
         raise_ff     <= raise_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      ksh_ff      <= ksh_in;
      key_ff      <= key_in;
      weight_ff   <= weight_in;
      last_ff     <= last_in;
      m_ff        <= m_in;
      dp_ff       <= dp_in;
      q_use_ff    <= q_use_in;
      p_leaf_ff   <= p_leaf_in;
      p_addr_ff   <= p_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/mwis_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the maximum-weight increasing subsequence unit, with its bind.
module mwis_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mwis_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mwis_pkg::rsp_type rsp_data
);

   // Hold a stalled response word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // One item at a time: stall straight after an accepted word.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while an item is in flight");

   // Running best never lags the chain ending here.
   a_best_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.best_so_far >= rsp_data.best_ending_here)
      else $error("running best below best ending here");

   // A chain sum is never the empty marker.
   a_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.best_ending_here != mwis_pkg::SUM_EMPTY)
      else $error("empty marker leaked into a response word");

endmodule

bind max_weight_increasing_subsequence_unit mwis_checker u_mwis_checker (.*);
